// ===== rtl/cdn_pkg.sv =====
// cdn_pkg: shared types, constants, reciprocals and tables of the calendar day converter
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps

package cdn_pkg;

   typedef enum logic [1:0] {
      OP_TO_DAYS  = 2'd0,
      OP_TO_CIVIL = 2'd1,
      OP_EPOCH    = 2'd2
   } cdn_op_type;

   typedef struct packed {
      logic signed [16:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
   } cdn_date_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } cdn_hms_type;

   // register stages from acceptance to the output register
   localparam int CDN_DEPTH         = 15;

   localparam int CDN_DAYS_PER_ERA  = 146097;
   localparam int CDN_DAYS_TO_EPOCH = 719468;
   // era biases keep every floor division on non-negative values
   localparam int CDN_CIVIL_ERAS    = 115;
   localparam int CDN_CIVIL_BIAS    = CDN_DAYS_TO_EPOCH + CDN_CIVIL_ERAS * CDN_DAYS_PER_ERA;
   localparam int CDN_YEAR_ERAS     = 82;
   localparam int CDN_YEAR_BIAS     = CDN_YEAR_ERAS * 400;
   localparam int CDN_DAYS_BIAS     = CDN_DAYS_TO_EPOCH + CDN_YEAR_ERAS * CDN_DAYS_PER_ERA;
   localparam int CDN_SEC_BIAS      = 2 * 86400;

   // ceil(2^k / d) reciprocals, exact over each operand range
   localparam longint unsigned CDN_RCP_675_HI = ((64'd1 << 27) + 64'd674) / 64'd675;
   localparam longint unsigned CDN_RCP_675_LO = ((64'd1 << 37) + 64'd674) / 64'd675;
   localparam longint unsigned CDN_RCP_ERA    = ((64'd1 << 44) + 64'd146096) / 64'd146097;
   localparam longint unsigned CDN_RCP_1460   = ((64'd1 << 29) + 64'd1459) / 64'd1460;
   localparam longint unsigned CDN_RCP_36524  = ((64'd1 << 34) + 64'd36523) / 64'd36524;
   localparam longint unsigned CDN_RCP_365    = ((64'd1 << 27) + 64'd364) / 64'd365;
   localparam longint unsigned CDN_RCP_400    = ((64'd1 << 26) + 64'd399) / 64'd400;
   localparam longint unsigned CDN_RCP_3600   = ((64'd1 << 29) + 64'd3599) / 64'd3600;
   localparam longint unsigned CDN_RCP_60     = ((64'd1 << 18) + 64'd59) / 64'd60;

   // first day of each month in a march-based year
   function automatic logic [8:0] cdn_month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd367;
      endcase
      return r;
   endfunction

   // civil month (0..15) to day of march-based year of its first day
   function automatic logic [8:0] cdn_day_base(input logic [3:0] month);
      logic [8:0] r;
      unique case (month)
         4'd0:    r = 9'd275;
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         4'd13:   r = 9'd306;
         4'd14:   r = 9'd337;
         default: r = 9'd367;
      endcase
      return r;
   endfunction

   // yoe / 100 for yoe below 400
   function automatic logic [1:0] cdn_centuries(input logic [8:0] yoe);
      logic [1:0] r;
      priority if (yoe >= 9'd300) r = 2'd3;
      else if (yoe >= 9'd200)    r = 2'd2;
      else if (yoe >= 9'd100)    r = 2'd1;
      else                       r = 2'd0;
      return r;
   endfunction

endpackage

// ===== rtl/cdn_seconds.sv =====
// cdn_seconds: five-stage floor split of zone-shifted epoch seconds into day and second of day
// depends on cdn_pkg
`timescale 1ns / 1ps

module cdn_seconds (
   input  logic               clock,
   input  logic               advance,
   input  logic [39:0]        unix_seconds,
   input  logic signed [17:0] tz_offset,
   output logic signed [24:0] day_number,
   output logic [16:0]        sec_of_day
);

   // stage 1: bias, split off the factor 128 of 86400
   logic [40:0] sb_in;
   logic [16:0] hi_ff;
   logic [16:0] lo_ff;
   logic [6:0]  low7_ff, low7_2_ff, low7_3_ff, low7_4_ff;
   // stage 2
   logic [34:0] p1_ff;
   logic [16:0] hi_2_ff, lo_2_ff;
   // stage 3
   logic [7:0]  q1_in, q1_ff, q1_4_ff;
   logic [16:0] r1_in;
   logic [26:0] x2_ff, x2_4_ff;
   // stage 4
   logic [54:0] p2_ff;
   // stage 5
   logic [17:0] q2_in;
   logic [26:0] r2_in;
   logic signed [24:0] dn_ff;
   logic [16:0] sod_ff;

   assign sb_in = 41'(42'(unix_seconds) + 42'(tz_offset) + 42'(cdn_pkg::CDN_SEC_BIAS));
   assign q1_in = 8'(p1_ff >> 27);
   assign r1_in = 17'(hi_2_ff - 17'(q1_in) * 17'd675);
   assign q2_in = 18'(p2_ff >> 37);
   assign r2_in = 27'(x2_4_ff - 27'(q2_in) * 27'd675);

   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff     <= sb_in[40:24];
         lo_ff     <= sb_in[23:7];
         low7_ff   <= sb_in[6:0];

         p1_ff     <= 35'(hi_ff) * 35'(cdn_pkg::CDN_RCP_675_HI);
         hi_2_ff   <= hi_ff;
         lo_2_ff   <= lo_ff;
         low7_2_ff <= low7_ff;

         q1_ff     <= q1_in;
         x2_ff     <= {r1_in[9:0], lo_2_ff};
         low7_3_ff <= low7_2_ff;

         p2_ff     <= 55'(x2_ff) * 55'(cdn_pkg::CDN_RCP_675_LO);
         x2_4_ff   <= x2_ff;
         q1_4_ff   <= q1_ff;
         low7_4_ff <= low7_3_ff;

         dn_ff     <= 25'({q1_4_ff, 17'b0}) + 25'(q2_in) - 25'd2;
         sod_ff    <= {r2_in[9:0], low7_4_ff};
      end
   end

   assign day_number = dn_ff;
   assign sec_of_day = sod_ff;

endmodule

// ===== rtl/cdn_days.sv =====
// cdn_days: five-stage civil date to day number datapath
// depends on cdn_pkg
`timescale 1ns / 1ps

module cdn_days (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [15:0] in_year,
   input  logic [3:0]         in_month,
   input  logic [4:0]         in_day,
   output logic signed [24:0] day_number
);

   logic [16:0]        yb_in, yb_ff, yb_2_ff;
   logic signed [9:0]  doy_in, doy_ff, doy_2_ff, doy_3_ff;
   logic [34:0]        pe_ff;
   logic [7:0]         era_in, era_ff;
   logic [8:0]         yoe_ff;
   logic signed [18:0] doe_ff;
   logic [25:0]        eb_ff;
   logic signed [24:0] dn_ff;

   // january and february belong to the year before
   assign yb_in  = 17'(18'(in_year) - 18'(in_month <= 4'd2) + 18'(cdn_pkg::CDN_YEAR_BIAS));
   assign doy_in = 10'(cdn_pkg::cdn_day_base(in_month)) + 10'(in_day) - 10'd1;
   assign era_in = 8'(pe_ff >> 26);

   always_ff @(posedge clock) begin
      if (advance) begin
         yb_ff    <= yb_in;
         doy_ff   <= doy_in;

         pe_ff    <= 35'(yb_ff) * 35'(cdn_pkg::CDN_RCP_400);
         yb_2_ff  <= yb_ff;
         doy_2_ff <= doy_ff;

         era_ff   <= era_in;
         yoe_ff   <= 9'(yb_2_ff - 17'(era_in) * 17'd400);
         doy_3_ff <= doy_2_ff;

         doe_ff   <= 19'(yoe_ff) * 19'd365 + 19'(yoe_ff >> 2)
                     - 19'(cdn_pkg::cdn_centuries(yoe_ff)) + 19'(doy_3_ff);
         eb_ff    <= 26'(era_ff) * 26'(cdn_pkg::CDN_DAYS_PER_ERA);

         dn_ff    <= 25'(27'(eb_ff) + 27'(doe_ff) - 27'(cdn_pkg::CDN_DAYS_BIAS));
      end
   end

   assign day_number = dn_ff;

endmodule

// ===== rtl/cdn_civil.sv =====
// cdn_civil: nine-stage day number to civil date datapath
// depends on cdn_pkg
`timescale 1ns / 1ps

module cdn_civil (
   input  logic                  clock,
   input  logic                  advance,
   input  logic signed [24:0]    day_number,
   output cdn_pkg::cdn_date_type date
);

   logic [25:0] zb_ff, zb_2_ff;
   logic [52:0] pe_ff;
   logic [7:0]  era_in, era_ff, era_4_ff, era_5_ff, era_6_ff;
   logic [17:0] doe_ff, doe_4_ff, doe_5_ff, doe_6_ff;
   logic [36:0] pa_ff, pb_ff;
   logic        last_ff;
   logic [17:0] ya_ff;
   logic [36:0] py_ff;
   logic [8:0]  yoe_in;
   logic [8:0]  doy_ff, doy_8_ff;
   logic signed [16:0] ybase_ff, ybase_8_ff;
   logic [3:0]  mp_in, mp_ff;
   logic [3:0]  month_in;
   cdn_pkg::cdn_date_type date_ff;

   assign era_in = 8'(pe_ff >> 44);
   assign yoe_in = 9'(py_ff >> 27);

   always_comb begin
      mp_in = 4'd0;
      for (int i = 1; i < 12; i++) begin
         mp_in = mp_in + 4'(doy_ff >= cdn_pkg::cdn_month_start(4'(i)));
      end
   end

   assign month_in = (mp_ff < 4'd10) ? mp_ff + 4'd3 : mp_ff - 4'd9;

   always_ff @(posedge clock) begin
      if (advance) begin
         zb_ff      <= 26'(27'(day_number) + 27'(cdn_pkg::CDN_CIVIL_BIAS));

         pe_ff      <= 53'(zb_ff) * 53'(cdn_pkg::CDN_RCP_ERA);
         zb_2_ff    <= zb_ff;

         era_ff     <= era_in;
         doe_ff     <= 18'(zb_2_ff - 26'(era_in) * 26'(cdn_pkg::CDN_DAYS_PER_ERA));

         pa_ff      <= 37'(doe_ff) * 37'(cdn_pkg::CDN_RCP_1460);
         pb_ff      <= 37'(doe_ff) * 37'(cdn_pkg::CDN_RCP_36524);
         last_ff    <= (doe_ff == 18'd146096);
         doe_4_ff   <= doe_ff;
         era_4_ff   <= era_ff;

         ya_ff      <= 18'(19'(doe_4_ff) - 19'(pa_ff >> 29) + 19'(pb_ff >> 34)
                       - 19'(last_ff));
         doe_5_ff   <= doe_4_ff;
         era_5_ff   <= era_4_ff;

         py_ff      <= 37'(ya_ff) * 37'(cdn_pkg::CDN_RCP_365);
         doe_6_ff   <= doe_5_ff;
         era_6_ff   <= era_5_ff;

         doy_ff     <= 9'(19'(doe_6_ff) - (19'(yoe_in) * 19'd365 + 19'(yoe_in >> 2)
                       - 19'(cdn_pkg::cdn_centuries(yoe_in))));
         ybase_ff   <= 17'(18'(era_6_ff) * 18'd400 + 18'(yoe_in)
                       - 18'(cdn_pkg::CDN_CIVIL_ERAS * 400));

         mp_ff      <= mp_in;
         doy_8_ff   <= doy_ff;
         ybase_8_ff <= ybase_ff;

         date_ff.day   <= 5'(doy_8_ff - cdn_pkg::cdn_month_start(mp_ff) + 9'd1);
         date_ff.month <= month_in;
         date_ff.year  <= ybase_8_ff + 17'(month_in <= 4'd2);
      end
   end

   assign date = date_ff;

endmodule

// ===== rtl/cdn_clock.sv =====
// cdn_clock: four-stage split of second of day into hour, minute and second
// depends on cdn_pkg
`timescale 1ns / 1ps

module cdn_clock (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [16:0]          sec_of_day,
   output cdn_pkg::cdn_hms_type hms
);

   logic [34:0] p_ff;
   logic [16:0] sod_ff;
   logic [4:0]  hh_in, hh_ff, hh_3_ff;
   logic [11:0] r_ff, r_3_ff;
   logic [24:0] p2_ff;
   logic [5:0]  mm_in;
   cdn_pkg::cdn_hms_type hms_ff;

   assign hh_in = 5'(p_ff >> 29);
   assign mm_in = 6'(p2_ff >> 18);

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff    <= 35'(sec_of_day) * 35'(cdn_pkg::CDN_RCP_3600);
         sod_ff  <= sec_of_day;

         hh_ff   <= hh_in;
         r_ff    <= 12'(sod_ff - 17'(hh_in) * 17'd3600);

         p2_ff   <= 25'(r_ff) * 25'(cdn_pkg::CDN_RCP_60);
         r_3_ff  <= r_ff;
         hh_3_ff <= hh_ff;

         hms_ff.hour   <= hh_3_ff;
         hms_ff.minute <= mm_in;
         hms_ff.second <= 6'(r_3_ff - 12'(mm_in) * 12'd60);
      end
   end

   assign hms = hms_ff;

endmodule

// ===== rtl/calendar_day_number_converter_unit.sv =====
// calendar_day_number_converter_unit: top level of the pipelined calendar converter
// depends on cdn_pkg, cdn_seconds, cdn_days, cdn_civil, cdn_clock
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  operation, date, day number, epoch seconds
//   rsp_         out         rsp_valid/rsp_stall  day number, date, hour, minute, second
//   csr_         in          csr_wr_en            tz_offset
//
// one item enters per cycle while req_stall is low; each item passes CDN_DEPTH register stages
// the pipe depth is set by the longest path: epoch split (5 stages), then the
// day to date chain (9 stages), then the output register
// a stall while rsp_valid is high freezes the whole pipe, so req_stall follows it
// synchronous active-high reset clears valid bits and tz_offset (to zero)
`timescale 1ns / 1ps

module calendar_day_number_converter_unit (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_in_year,
   input  logic [3:0]         req_in_month,
   input  logic [4:0]         req_in_day,
   input  logic signed [24:0] req_in_day_number,
   input  logic [39:0]        req_unix_seconds,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_out_day_number,
   output logic signed [16:0] rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [4:0]         rsp_out_hour,
   output logic [5:0]         rsp_out_minute,
   output logic [5:0]         rsp_out_second,

   input  logic               csr_wr_en,
   input  logic signed [17:0] csr_wr_data
);

   logic advance;

   // configuration
   logic signed [17:0] tz_offset_ff;

   // control travelling with each item; stage i+1 of the pipe is index i
   logic                valid_ff [cdn_pkg::CDN_DEPTH];
   cdn_pkg::cdn_op_type op_ff    [cdn_pkg::CDN_DEPTH];

   // datapath results
   logic signed [24:0]    sec_dn;
   logic [16:0]           sec_sod;
   logic signed [24:0]    days_dn;
   logic signed [24:0]    civil_in;
   cdn_pkg::cdn_date_type civil_date;
   cdn_pkg::cdn_hms_type  clock_hms;

   // alignment delay lines
   logic signed [24:0]   dnum_ff  [5];   // request day number up to the date chain
   logic signed [24:0]   ddays_ff [9];   // date-to-day result up to the output
   logic signed [24:0]   dsec_ff  [9];   // epoch day number up to the output
   cdn_pkg::cdn_hms_type dhms_ff  [5];   // time of day up to the output

   // output register
   logic signed [24:0]    out_dn_ff;
   cdn_pkg::cdn_date_type out_date_ff;
   cdn_pkg::cdn_hms_type  out_hms_ff;

   // whole pipe moves unless a finished item is held at the output
   assign advance   = !(valid_ff[cdn_pkg::CDN_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_ff <= '0;
      end else if (csr_wr_en) begin
         tz_offset_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cdn_pkg::CDN_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < cdn_pkg::CDN_DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // op travels with the item; unused code 3 passes as is and yields zeros
   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0] <= cdn_pkg::cdn_op_type'(req_operation);
         for (int i = 1; i < cdn_pkg::CDN_DEPTH; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   cdn_seconds u_seconds (
      .clock         (clock),
      .advance       (advance),
      .unix_seconds  (req_unix_seconds),
      .tz_offset     (tz_offset_ff),
      .day_number    (sec_dn),
      .sec_of_day    (sec_sod)
   );

   cdn_days u_days (
      .clock      (clock),
      .advance    (advance),
      .in_year    (req_in_year),
      .in_month   (req_in_month),
      .in_day     (req_in_day),
      .day_number (days_dn)
   );

   // date chain is shared: day number from the request or from the epoch split
   assign civil_in = (op_ff[4] == cdn_pkg::OP_TO_CIVIL) ? dnum_ff[4] : sec_dn;

   cdn_civil u_civil (
      .clock      (clock),
      .advance    (advance),
      .day_number (civil_in),
      .date       (civil_date)
   );

   cdn_clock u_clock (
      .clock      (clock),
      .advance    (advance),
      .sec_of_day (sec_sod),
      .hms        (clock_hms)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         dnum_ff[0]  <= req_in_day_number;
         ddays_ff[0] <= days_dn;
         dsec_ff[0]  <= sec_dn;
         dhms_ff[0]  <= clock_hms;
         for (int i = 1; i < 5; i++) begin
            dnum_ff[i] <= dnum_ff[i-1];
            dhms_ff[i] <= dhms_ff[i-1];
         end
         for (int i = 1; i < 9; i++) begin
            ddays_ff[i] <= ddays_ff[i-1];
            dsec_ff[i]  <= dsec_ff[i-1];
         end
      end
   end

   // fields an operation does not produce are zero
   always_ff @(posedge clock) begin
      if (advance) begin
         unique case (op_ff[cdn_pkg::CDN_DEPTH-2])
            cdn_pkg::OP_TO_DAYS: begin
               out_dn_ff   <= ddays_ff[8];
               out_date_ff <= '0;
               out_hms_ff  <= '0;
            end
            cdn_pkg::OP_TO_CIVIL: begin
               out_dn_ff   <= '0;
               out_date_ff <= civil_date;
               out_hms_ff  <= '0;
            end
            cdn_pkg::OP_EPOCH: begin
               out_dn_ff   <= dsec_ff[8];
               out_date_ff <= civil_date;
               out_hms_ff  <= dhms_ff[4];
            end
            default: begin
               out_dn_ff   <= '0;
               out_date_ff <= '0;
               out_hms_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid          = valid_ff[cdn_pkg::CDN_DEPTH-1];
   assign rsp_out_day_number = out_dn_ff;
   assign rsp_out_year       = out_date_ff.year;
   assign rsp_out_month      = out_date_ff.month;
   assign rsp_out_day        = out_date_ff.day;
   assign rsp_out_hour       = out_hms_ff.hour;
   assign rsp_out_minute     = out_hms_ff.minute;
   assign rsp_out_second     = out_hms_ff.second;

`ifndef SYNTH
   // a moving pipe shifts the last valid bit into the output
   a_valid_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> (valid_ff[cdn_pkg::CDN_DEPTH-1] == $past(valid_ff[cdn_pkg::CDN_DEPTH-2])))
      else $error("valid bit lost or repeated at the output stage");

   // date to day number gives no date fields and a zero hour
   a_days_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff[cdn_pkg::CDN_DEPTH-1] == cdn_pkg::OP_TO_DAYS) |->
         (rsp_out_year == 17'sd0 && rsp_out_month == 4'd0 && rsp_out_day == 5'd0 &&
          rsp_out_hour == 5'd0))
      else $error("date fields not zero for date to day number");

   // the date chain always lands on a month from 1 to 12 and a day of at least 1
   a_civil_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (op_ff[cdn_pkg::CDN_DEPTH-1] == cdn_pkg::OP_TO_CIVIL ||
                     op_ff[cdn_pkg::CDN_DEPTH-1] == cdn_pkg::OP_EPOCH)) |->
         (rsp_out_month >= 4'd1 && rsp_out_month <= 4'd12 && rsp_out_day >= 5'd1))
      else $error("month or day out of range");

   // time of day split stays in range
   a_hms_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && op_ff[cdn_pkg::CDN_DEPTH-1] == cdn_pkg::OP_EPOCH) |->
         (rsp_out_hour < 5'd24 && rsp_out_minute < 6'd60 && rsp_out_second < 6'd60))
      else $error("hour, minute or second out of range");
`endif

endmodule

// ===== tb/tb_calendar_day_number_converter_unit.sv =====
// tb_calendar_day_number_converter_unit: self-checking bench for the calendar converter
// drives dated, day-number and epoch items, predicts each result in place and compares it
// depends on cdn_pkg and calendar_day_number_converter_unit
`timescale 1ns / 1ps

module tb_calendar_day_number_converter_unit;

   localparam int LATENCY     = cdn_pkg::CDN_DEPTH;
   localparam int IDLE_LIMIT  = 5000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [24:0] day_number;
      logic signed [16:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } conv_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic signed [15:0] req_in_year = '0;
   logic [3:0]         req_in_month = '0;
   logic [4:0]         req_in_day = '0;
   logic signed [24:0] req_in_day_number = '0;
   logic [39:0]        req_unix_seconds = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [24:0] rsp_out_day_number;
   logic signed [16:0] rsp_out_year;
   logic [3:0]         rsp_out_month;
   logic [4:0]         rsp_out_day;
   logic [4:0]         rsp_out_hour;
   logic [5:0]         rsp_out_minute;
   logic [5:0]         rsp_out_second;
   logic               csr_wr_en = 1'b0;
   logic signed [17:0] csr_wr_data = '0;

   conv_result_type expected_dates[$];
   longint         tz_seconds = 0;   // local copy of the offset register
   int             error_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   bit             stall_enable = 1'b1;

   calendar_day_number_converter_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_in_year        (req_in_year),
      .req_in_month       (req_in_month),
      .req_in_day         (req_in_day),
      .req_in_day_number  (req_in_day_number),
      .req_unix_seconds   (req_unix_seconds),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_out_hour       (rsp_out_hour),
      .rsp_out_minute     (rsp_out_minute),
      .rsp_out_second     (rsp_out_second),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor division, rounding toward minus infinity
   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if (a % b < 0) q = q - 1;
      return q;
   endfunction

   // days since 1970-01-01 for a civil date, march-based year on 400-year eras
   function automatic longint date_to_days(input longint yr, input longint mon,
                                           input longint dom);
      longint y, era, yoe, mi, doy;
      y   = yr - ((mon <= 2) ? 1 : 0);
      era = floor_div(y, 400);
      yoe = y - era * 400;
      mi  = (mon > 2) ? mon - 3 : mon + 9;
      doy = (153 * mi + 2) / 5 + dom - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
   endfunction

   // civil date of a day number, fills the date fields of r
   function automatic void days_to_date(input longint days, inout conv_result_type r);
      longint z, era, doe, yoe, doy, mp, m;
      z   = days + 719468;
      era = floor_div(z, 146097);
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      r.day   = 5'(doy - (153 * mp + 2) / 5 + 1);
      r.month = 4'(m);
      r.year  = 17'(yoe + era * 400 + ((m <= 2) ? 1 : 0));
   endfunction

   function automatic conv_result_type convert_date(input logic [1:0] op,
         input logic signed [15:0] yr, input logic [3:0] mon, input logic [4:0] dom,
         input logic signed [24:0] dnum, input logic [39:0] secs);
      conv_result_type r;
      longint shifted, dn, sod;
      r = '0;
      case (op)
         cdn_pkg::OP_TO_DAYS:  r.day_number = 25'(date_to_days(longint'(yr),
                                                   longint'(mon), longint'(dom)));
         cdn_pkg::OP_TO_CIVIL: days_to_date(longint'(dnum), r);
         cdn_pkg::OP_EPOCH: begin
            shifted = longint'(secs) + tz_seconds;
            dn  = floor_div(shifted, 86400);
            sod = shifted - dn * 86400;
            r.day_number = 25'(dn);
            days_to_date(dn, r);
            r.hour   = 5'(sod / 3600);
            r.minute = 6'((sod % 3600) / 60);
            r.second = 6'(sod % 60);
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // one item through the handshake, with random gaps between bursts
   task automatic send_item(input logic [1:0] op, input logic signed [15:0] yr,
         input logic [3:0] mon, input logic [4:0] dom, input logic signed [24:0] dnum,
         input logic [39:0] secs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_in_year       <= yr;
      req_in_month      <= mon;
      req_in_day        <= dom;
      req_in_day_number <= dnum;
      req_unix_seconds  <= secs;
      expected_dates.push_back(convert_date(op, yr, mon, dom, dnum, secs));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_offset(input longint value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 18'(value);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tz_seconds  = longint'(signed'(18'(value)));
      @(posedge clock);
   endtask

   task automatic send_random(input int count);
      logic [1:0] op;
      logic [15:0] yr;
      for (int i = 0; i < count; i++) begin
         op = 2'($urandom_range(0, 9) == 0 ? OP_UNUSED : $urandom_range(0, 2));
         // mostly realistic years, sometimes the whole field
         yr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1600, 2400));
         send_item(op, yr, 4'($urandom), 5'($urandom),
                   25'($urandom), {8'($urandom), 32'($urandom)} >>
                   ($urandom_range(0, 1) ? 0 : 9));
      end
   endtask

   task automatic test_date_to_days();
      send_item(cdn_pkg::OP_TO_DAYS, 16'sd1970, 4'd1, 5'd1, '0, '0);
      send_item(cdn_pkg::OP_TO_DAYS, 16'sd2000, 4'd2, 5'd29, '0, '0);
      send_item(cdn_pkg::OP_TO_DAYS, 16'sh7fff, 4'd12, 5'd31, '0, '0);
      send_item(cdn_pkg::OP_TO_DAYS, 16'sh8000, 4'd1, 5'd1, '0, '0);
      send_item(cdn_pkg::OP_TO_DAYS, 16'sd1900, 4'd0, 5'd0, '0, '0);    // month zero, day zero
      send_item(cdn_pkg::OP_TO_DAYS, 16'sd2024, 4'd15, 5'd31, '0, '0);  // month past december
      send_item(cdn_pkg::OP_TO_DAYS, -16'sd1, 4'd13, 5'd31, '0, '0);    // month past december in year -1
      send_item(cdn_pkg::OP_TO_DAYS, 16'sd0, 4'd3, 5'd1, '0, '0);
   endtask

   task automatic test_days_to_date();
      send_item(cdn_pkg::OP_TO_CIVIL, '0, '0, '0, 25'sd0, '0);
      send_item(cdn_pkg::OP_TO_CIVIL, '0, '0, '0, -25'sd1, '0);
      send_item(cdn_pkg::OP_TO_CIVIL, '0, '0, '0, 25'sh0ffffff, '0);
      send_item(cdn_pkg::OP_TO_CIVIL, '0, '0, '0, 25'sh1000000, '0);
      send_item(cdn_pkg::OP_TO_CIVIL, '0, '0, '0, 25'sd11016, '0);
      send_item(OP_UNUSED, 16'sh7fff, 4'hf, 5'h1f, 25'sh1ffffff, '1);
   endtask

   task automatic test_epoch();
      send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'd0);
      send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'hff_ffff_ffff);
      send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'd86399);
      send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'd951782400);
   endtask

   task automatic test_offsets();
      longint offsets[6] = '{-86399, 86399, -131072, 131071, 3600, 0};
      foreach (offsets[k]) begin
         drain_pipe();
         write_offset(offsets[k]);
         send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'd0);
         send_item(cdn_pkg::OP_EPOCH, '0, '0, '0, '0, 40'hff_ffff_ffff);
         send_random(22);
      end
   endtask

   task automatic test_random_traffic();
      send_random(150);
      // hold off until the pipe is empty, then continue
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      send_random(50);
      stall_enable = 1'b0;   // stretch with no output stall
      send_random(40);
      stall_enable = 1'b1;
   endtask

   // receiver stall pattern: rsp_stall drawn at random, held low during reset or while stall_enable is low
   initial begin
      int run;
      forever begin
         run = $urandom_range(1, 8);
         repeat (run) begin
            @(posedge clock);
            rsp_stall <= stall_enable && !reset ? ($urandom_range(0, 2) == 0) : 1'b0;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dates.size() == 0) begin
            report_mismatch("unexpected result item", 1, 0);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_out_day_number !== want.day_number)
               report_mismatch("day_number", rsp_out_day_number, want.day_number);
            if (rsp_out_year !== want.year) report_mismatch("year", rsp_out_year, want.year);
            if (rsp_out_month !== want.month) report_mismatch("month", rsp_out_month, want.month);
            if (rsp_out_day !== want.day) report_mismatch("day", rsp_out_day, want.day);
            if (rsp_out_hour !== want.hour) report_mismatch("hour", rsp_out_hour, want.hour);
            if (rsp_out_minute !== want.minute)
               report_mismatch("minute", rsp_out_minute, want.minute);
            if (rsp_out_second !== want.second)
               report_mismatch("second", rsp_out_second, want.second);
         end
      end
   end

   // watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_date_to_days();
      test_days_to_date();
      test_epoch();
      test_random_traffic();
      test_offsets();
      drain_pipe();
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
